// File: rtl/jlcs_pkg.sv
// Package for the Jacobi Laplace cylinder solver.
// Holds grid constants, state and command types shared by the interfaces, controller, datapath and top level.
// No dependencies.
package jlcs_pkg;

  localparam int unsigned GridW   = 64;
  localparam int unsigned GridH   = 64;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SweepW  = 16;
  localparam int unsigned DivCntW = 2;
  localparam int unsigned Cells   = GridW * GridH;

  // Division by GridW-1 multiplies by ceil(2^RecipSh / (GridW-1)), which is 2^32 plus RecipLo.
  localparam int unsigned RecipW  = 27;
  localparam int unsigned RecipSh = 38;
  localparam int unsigned ProdW   = DataW + RecipW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecipSh) + 64'(GridW - 2)) / 64'(GridW - 1);
  localparam logic [RecipW-1:0]  RecipLo = RecipW'(RecipFull);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(2);

  localparam logic [CoordW-1:0] ColLast  = CoordW'(GridW - 1);
  localparam logic [CoordW-1:0] RowLast  = CoordW'(GridH - 1);
  localparam logic [CoordW-1:0] ColInner = CoordW'(GridW - 2);
  localparam logic [CoordW-1:0] RowInner = CoordW'(GridH - 2);
  localparam logic [6:0]        Divisor  = 7'(GridW - 1);

  localparam logic CmdSolve = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic [2:0] RegInflowSpeed   = 3'd0;
  localparam logic [2:0] RegTolerance     = 3'd1;
  localparam logic [2:0] RegMaxSweeps     = 3'd2;
  localparam logic [2:0] RegCylinderCol   = 3'd3;
  localparam logic [2:0] RegCylinderRow   = 3'd4;
  localparam logic [2:0] RegCylinderRadius = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StRdAddr,
    StRdData,
    StDiv,
    StBuild,
    StCheck,
    StSweep,
    StSwEnd,
    StFinish
  } state_e;

  typedef struct packed {
    logic accept;
    logic solve_init;
    logic div_step;
    logic bld_clr;
    logic bld_step;
    logic sw_start;
    logic sw_step;
    logic sw_end;
    logic load_rd;
    logic load_solve;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic bld_last;
    logic cell_last;
    logic sweeps_full;
    logic maxd_below;
  } dp_status_t;

endpackage

// File: rtl/jlcs_ifs.sv
// Channel interfaces for the solver command and result streams.
// Depends on jlcs_pkg.
interface jlcs_in_if;
  import jlcs_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  modport source (output valid, cmd, col, row, input ready);
  modport sink (input valid, cmd, col, row, output ready);
endinterface

interface jlcs_out_if;
  import jlcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  potential;
  logic [SweepW-1:0] sweeps_done;
  logic              converged;
  modport source (output valid, potential, sweeps_done, converged, input ready);
  modport sink (input valid, potential, sweeps_done, converged, output ready);
endinterface

// File: rtl/jlcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jlcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/jlcs_ctrl.sv
// Controller state machine of the solver: sequencing of read, build and sweeps.
// Depends on jlcs_pkg.
module jlcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  jlcs_pkg::dp_status_t sts_i,
  output jlcs_pkg::ctrl_cmd_t  cmd_o
);
  import jlcs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_cmd_i == CmdRead) begin
            state_d = StRdAddr;
          end else begin
            cmd_o.solve_init = 1'b1;
            state_d          = StDiv;
          end
        end
      end
      StRdAddr: state_d = StRdData;
      StRdData: begin
        cmd_o.load_rd = 1'b1;
        state_d       = StIdle;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.bld_clr = 1'b1;
          state_d       = StBuild;
        end
      end
      StBuild: begin
        cmd_o.bld_step = 1'b1;
        if (sts_i.bld_last) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.sweeps_full) begin
          state_d = StFinish;
        end else begin
          cmd_o.sw_start = 1'b1;
          state_d        = StSweep;
        end
      end
      StSweep: begin
        cmd_o.sw_step = 1'b1;
        if (sts_i.cell_last) begin
          state_d = StSwEnd;
        end
      end
      StSwEnd: begin
        cmd_o.sw_end = 1'b1;
        state_d      = sts_i.maxd_below ? StFinish : StCheck;
      end
      StFinish: begin
        cmd_o.load_solve = 1'b1;
        state_d          = StIdle;
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.load_rd || cmd_o.load_solve) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end
endmodule

// File: rtl/jlcs_datapath.sv
// Datapath of the solver: grid buffers, boundary divider, stencil accumulator.
// Depends on jlcs_pkg and jlcs_ram.
module jlcs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jlcs_pkg::ctrl_cmd_t         cmd_i,
  output jlcs_pkg::dp_status_t        sts_o,
  input  logic [jlcs_pkg::CoordW-1:0] in_col_i,
  input  logic [jlcs_pkg::CoordW-1:0] in_row_i,
  input  logic [jlcs_pkg::DataW-1:0]  speed_i,
  input  logic [jlcs_pkg::DataW-1:0]  tol_i,
  input  logic [jlcs_pkg::SweepW-1:0] max_sweeps_i,
  input  logic [jlcs_pkg::CoordW-1:0] cyl_col_i,
  input  logic [jlcs_pkg::CoordW-1:0] cyl_row_i,
  input  logic [jlcs_pkg::CoordW-1:0] cyl_rad_i,
  output logic [jlcs_pkg::DataW-1:0]  potential_o,
  output logic [jlcs_pkg::SweepW-1:0] sweeps_done_o,
  output logic                        converged_o
);
  import jlcs_pkg::*;

  logic [CoordW-1:0]  rd_col_q, rd_row_q;
  logic [CoordW-1:0]  row_q, row_d, col_q, col_d;
  logic [2:0]         phase_q, phase_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [DataW-1:0]   div_sh_q, div_sh_d;
  logic [5:0]         rem_q, rem_d;
  logic [DataW-1:0]   acc_q, acc_d;
  logic [5:0]         accr_q, accr_d;
  logic [DataW+1:0]   sum_q, sum_d;
  logic [DataW-1:0]   maxd_q, maxd_d;
  logic [SweepW-1:0]  n_q, n_d;
  logic               conv_q, conv_d, cur_b_q, cur_b_d;
  logic [DataW-1:0]   pot_q;
  logic [SweepW-1:0]  swd_q;
  logic               cvd_q;

  logic signed [13:0] dx, dy;
  logic [14:0]        dist2;
  logic [11:0]        rad2;
  logic               in_cyl;
  logic [6:0]         accr_t;
  logic [2*DataW:0]   qsum;
  logic [DataW-1:0]   bval, rdata, a_rdata, b_rdata, v, diff;
  logic [AddrW-1:0]   raddr, waddr;
  logic               we_a, we_b, cell_adv;
  logic [DataW-1:0]   wdata;

  assign dx     = 14'(signed'({1'b0, col_q})) - 14'(signed'({1'b0, cyl_col_i}));
  assign dy     = 14'(signed'({1'b0, row_q})) - 14'(signed'({1'b0, cyl_row_i}));
  assign dist2  = 15'(unsigned'(dx * dx)) + 15'(unsigned'(dy * dy));
  assign rad2   = {6'd0, cyl_rad_i} * {6'd0, cyl_rad_i};
  assign in_cyl = dist2 <= {3'd0, rad2};

  assign qsum   = {1'b0, speed_i, {DataW{1'b0}}} + {{(DataW+1-RecipW){1'b0}}, prod_q};
  assign accr_t = {1'b0, accr_q} + {1'b0, rem_q};

  always_comb begin
    bval = ((row_q == '0) || (row_q == RowLast)) ? acc_q : '0;
    if (col_q == '0) begin
      bval = '0;
    end
    if (col_q == ColLast) begin
      bval = speed_i;
    end
    if (in_cyl) begin
      bval = '0;
    end
  end

  assign rdata = cur_b_q ? b_rdata : a_rdata;
  assign v     = sum_q[DataW+1:2];
  assign diff  = (v > rdata) ? v - rdata : rdata - v;

  always_comb begin
    unique case (phase_q)
      3'd0:    raddr = {row_q, col_q - 1'b1};
      3'd1:    raddr = {row_q, col_q + 1'b1};
      3'd2:    raddr = {row_q - 1'b1, col_q};
      3'd3:    raddr = {row_q + 1'b1, col_q};
      default: raddr = {row_q, col_q};
    endcase
    if (!cmd_i.sw_step) begin
      raddr = {rd_row_q, rd_col_q};
    end
  end

  assign cell_adv = cmd_i.sw_step && (in_cyl || (phase_q == 3'd5));
  assign waddr    = {row_q, col_q};
  assign wdata    = cmd_i.bld_step ? bval : v;
  assign we_a     = cmd_i.bld_step || (cmd_i.sw_step && !in_cyl && phase_q == 3'd5 && cur_b_q);
  assign we_b     = cmd_i.bld_step || (cmd_i.sw_step && !in_cyl && phase_q == 3'd5 && !cur_b_q);

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    phase_d   = phase_q;
    div_cnt_d = div_cnt_q;
    prod_d    = prod_q;
    div_sh_d  = div_sh_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    accr_d    = accr_q;
    sum_d     = sum_q;
    maxd_d    = maxd_q;
    n_d       = n_q;
    conv_d    = conv_q;
    cur_b_d   = cur_b_q;
    if (cmd_i.solve_init) begin
      n_d       = '0;
      conv_d    = 1'b0;
      cur_b_d   = 1'b0;
      div_cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      div_cnt_d = div_cnt_q + 1'b1;
      if (div_cnt_q == '0) begin
        prod_d = {{RecipW{1'b0}}, speed_i} * {{DataW{1'b0}}, RecipLo};
      end
      if (div_cnt_q == DivCntW'(1)) begin
        div_sh_d = DataW'(qsum[2*DataW:RecipSh]);
      end
      if (div_cnt_q == DivLast) begin
        rem_d = speed_i[5:0] + div_sh_q[5:0];
      end
    end
    if (cmd_i.bld_clr) begin
      row_d  = '0;
      col_d  = '0;
      acc_d  = '0;
      accr_d = '0;
    end
    if (cmd_i.bld_step) begin
      if (col_q == ColLast) begin
        col_d  = '0;
        row_d  = row_q + 1'b1;
        acc_d  = '0;
        accr_d = '0;
      end else begin
        col_d = col_q + 1'b1;
        if (accr_t >= Divisor) begin
          accr_d = 6'(accr_t - Divisor);
          acc_d  = acc_q + div_sh_q + 1'b1;
        end else begin
          accr_d = accr_t[5:0];
          acc_d  = acc_q + div_sh_q;
        end
      end
    end
    if (cmd_i.sw_start) begin
      row_d   = 6'd1;
      col_d   = 6'd1;
      phase_d = '0;
      maxd_d  = '0;
    end
    if (cmd_i.sw_step) begin
      if (phase_q == 3'd0) begin
        sum_d = '0;
      end else if (phase_q != 3'd5) begin
        sum_d = sum_q + {2'b00, rdata};
      end
      if (phase_q == 3'd5 && !in_cyl && diff > maxd_q) begin
        maxd_d = diff;
      end
      if (cell_adv) begin
        phase_d = '0;
        if (col_q == ColInner) begin
          col_d = 6'd1;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
    if (cmd_i.sw_end) begin
      cur_b_d = !cur_b_q;
      n_d     = n_q + 1'b1;
      conv_d  = maxd_q < tol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      phase_q   <= '0;
      div_cnt_q <= '0;
      n_q       <= '0;
      conv_q    <= 1'b0;
      cur_b_q   <= 1'b0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      phase_q   <= phase_d;
      div_cnt_q <= div_cnt_d;
      n_q       <= n_d;
      conv_q    <= conv_d;
      cur_b_q   <= cur_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    div_sh_q <= div_sh_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    accr_q   <= accr_d;
    sum_q    <= sum_d;
    maxd_q   <= maxd_d;
    if (cmd_i.accept) begin
      rd_col_q <= in_col_i;
      rd_row_q <= in_row_i;
    end
    if (cmd_i.load_rd) begin
      pot_q <= rdata;
      swd_q <= '0;
      cvd_q <= 1'b0;
    end else if (cmd_i.load_solve) begin
      pot_q <= '0;
      swd_q <= n_q;
      cvd_q <= conv_q;
    end
  end

  jlcs_ram #(.Width(DataW), .Depth(Cells)) u_grid_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  jlcs_ram #(.Width(DataW), .Depth(Cells)) u_grid_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (b_rdata)
  );

  assign sts_o.div_done    = div_cnt_q == DivLast;
  assign sts_o.bld_last    = (row_q == RowLast) && (col_q == ColLast);
  assign sts_o.cell_last   = cell_adv && (row_q == RowInner) && (col_q == ColInner);
  assign sts_o.sweeps_full = n_q >= max_sweeps_i;
  assign sts_o.maxd_below  = maxd_q < tol_i;

  assign potential_o   = pot_q;
  assign sweeps_done_o = swd_q;
  assign converged_o   = cvd_q;
endmodule

// File: rtl/jacobi_laplace_cylinder_solver.sv
// Top level of the Jacobi Laplace cylinder solver: APB registers and channels.
// A read passes through RdAddr and RdData; one read is in flight at a time.
// A solve runs the divider, the grid build and the sweeps, paced by the single
// read port per grid RAM: a cell outside the cylinder reads its neighbours in turn.
// Reset is asynchronous and active low; grid contents are undefined until a solve.
module jacobi_laplace_cylinder_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  jlcs_in_if.sink     in_ch,
  jlcs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jlcs_pkg::*;

  logic [DataW-1:0]  speed_q, tol_q;
  logic [SweepW-1:0] max_sweeps_q;
  logic [CoordW-1:0] cyl_col_q, cyl_row_q, cyl_rad_q;
  logic              cfg_we;
  logic [2:0]        reg_idx;
  ctrl_cmd_t         cmd;
  dp_status_t        sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q      <= 32'h8000_0000;
      tol_q        <= 32'd2147;
      max_sweeps_q <= 16'd10000;
      cyl_col_q    <= 6'd32;
      cyl_row_q    <= 6'd32;
      cyl_rad_q    <= 6'd8;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegInflowSpeed:    speed_q      <= pwdata;
        RegTolerance:      tol_q        <= pwdata;
        RegMaxSweeps:      max_sweeps_q <= pwdata[SweepW-1:0];
        RegCylinderCol:    cyl_col_q    <= pwdata[CoordW-1:0];
        RegCylinderRow:    cyl_row_q    <= pwdata[CoordW-1:0];
        RegCylinderRadius: cyl_rad_q    <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegInflowSpeed:    prdata = speed_q;
      RegTolerance:      prdata = tol_q;
      RegMaxSweeps:      prdata = {16'd0, max_sweeps_q};
      RegCylinderCol:    prdata = {26'd0, cyl_col_q};
      RegCylinderRow:    prdata = {26'd0, cyl_row_q};
      RegCylinderRadius: prdata = {26'd0, cyl_rad_q};
      default:           prdata = '0;
    endcase
  end

  jlcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_cmd_i    (in_ch.cmd),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jlcs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_col_i      (in_ch.col),
    .in_row_i      (in_ch.row),
    .speed_i       (speed_q),
    .tol_i         (tol_q),
    .max_sweeps_i  (max_sweeps_q),
    .cyl_col_i     (cyl_col_q),
    .cyl_row_i     (cyl_row_q),
    .cyl_rad_i     (cyl_rad_q),
    .potential_o   (out_ch.potential),
    .sweeps_done_o (out_ch.sweeps_done),
    .converged_o   (out_ch.converged)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a command is still running");

  a_conv_needs_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.converged |-> out_ch.sweeps_done != 16'd0)
    else $error("converged result without any sweep");

  a_solve_no_potential: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.sweeps_done != 16'd0 |-> out_ch.potential == 32'd0)
    else $error("solve result carries a potential");
`endif
endmodule

// File: tb/jacobi_laplace_cylinder_solver_tb.sv
// Testbench for the Jacobi Laplace cylinder solver: solves and cell reads under random
// flow control, checked against an in-bench grid predictor. Depends on jlcs_pkg, the
// channel interfaces and the solver top level.
module jacobi_laplace_cylinder_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jlcs_pkg::*;

  localparam int unsigned StallLimit = 400000;

  typedef struct {
    logic              cmd;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } cell_cmd_t;

  typedef struct {
    logic [DataW-1:0]  potential;
    logic [SweepW-1:0] sweeps;
    logic              conv;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jlcs_in_if in_ch ();
  jlcs_out_if out_ch ();

  jacobi_laplace_cylinder_solver dut (
    .clk_i, .rst_ni, .in_ch(in_ch), .out_ch(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  cell_cmd_t pending_cmds[$];
  answer_t   answers_due[$];
  int        mismatches = 0;
  int        accepted_cmds = 0;
  int        stall_cycles = 0;
  bit        took = 1'b0;
  int        send_idle = 35;
  int        recv_idle = 45;

  logic [31:0] speed_q = 32'h8000_0000;
  logic [31:0] tol_q = 32'd2147;
  logic [15:0] limit_q = 16'd10000;
  logic [5:0]  cyl_col_q = 6'd32, cyl_row_q = 6'd32, cyl_rad_q = 6'd8;
  logic [31:0] field [2][Cells];
  bit          live_b = 1'b0;

  function automatic bit in_cyl(int c, int r);
    int dx, dy;
    dx = c - int'(cyl_col_q);
    dy = r - int'(cyl_row_q);
    return dx * dx + dy * dy <= int'(cyl_rad_q) * int'(cyl_rad_q);
  endfunction

  function automatic answer_t solve_field();
    answer_t a;
    logic [31:0] v, d, maxd;
    logic [33:0] s;
    int k, n;
    n = 0;
    a.potential = '0;
    a.conv = 1'b0;
    for (int r = 0; r < GridH; r++) begin
      for (int c = 0; c < GridW; c++) begin
        v = '0;
        if (r == 0 || r == GridH - 1) v = 32'((64'(speed_q) * 64'(c)) / 64'(GridW - 1));
        if (c == 0) v = '0;
        if (c == GridW - 1) v = speed_q;
        if (in_cyl(c, r)) v = '0;
        field[0][r * GridW + c] = v;
        field[1][r * GridW + c] = v;
      end
    end
    live_b = 1'b0;
    while (n < int'(limit_q)) begin
      maxd = '0;
      for (int r = 1; r < GridH - 1; r++) begin
        for (int c = 1; c < GridW - 1; c++) begin
          k = r * GridW + c;
          if (!in_cyl(c, r)) begin
            s = 34'(field[live_b][k-1]) + 34'(field[live_b][k+1]) +
                34'(field[live_b][k-GridW]) + 34'(field[live_b][k+GridW]);
            v = s[33:2];
            field[!live_b][k] = v;
            d = (v > field[live_b][k]) ? v - field[live_b][k] : field[live_b][k] - v;
            if (d > maxd) maxd = d;
          end
        end
      end
      live_b = !live_b;
      n++;
      if (maxd < tol_q) begin
        a.conv = 1'b1;
        break;
      end
    end
    a.sweeps = 16'(n);
    return a;
  endfunction

  function automatic answer_t predict(cell_cmd_t x);
    answer_t a;
    if (x.cmd == CmdSolve) begin
      a = solve_field();
    end else begin
      a.potential = field[live_b][int'(x.row) * GridW + int'(x.col)];
      a.sweeps = '0;
      a.conv = 1'b0;
    end
    return a;
  endfunction

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      answers_due.push_back(predict(pending_cmds.pop_front()));
      took = 1'b1;
      accepted_cmds++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took) begin
      took = 1'b0;
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= pending_cmds[0].cmd;
        in_ch.col <= pending_cmds[0].col;
        in_ch.row <= pending_cmds[0].row;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: potential %h", out_ch.potential);
      end else begin
        answer_t e;
        e = answers_due.pop_front();
        if (e.potential !== out_ch.potential || e.sweeps !== out_ch.sweeps_done ||
            e.conv !== out_ch.converged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pot %h sweeps %0d conv %b, got pot %h sweeps %0d conv %b",
                     e.potential, e.sweeps, e.conv, out_ch.potential,
                     out_ch.sweeps_done, out_ch.converged);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (accepted_cmds >= 1200) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (accepted_cmds >= 600) begin
      send_idle = 45;
      recv_idle = 35;
    end
  end

  task automatic push_cmd(logic cmd, logic [5:0] c, logic [5:0] r);
    cell_cmd_t x;
    x.cmd = cmd;
    x.col = c;
    x.row = r;
    pending_cmds.push_back(x);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegInflowSpeed: speed_q = val;
      RegTolerance:   tol_q = val;
      RegMaxSweeps:   limit_q = val[15:0];
      RegCylinderCol: cyl_col_q = val[5:0];
      RegCylinderRow: cyl_row_q = val[5:0];
      default:        cyl_rad_q = val[5:0];
    endcase
  endtask

  task automatic settle();
    wait (pending_cmds.size() == 0 && answers_due.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_all(logic [31:0] spd, logic [31:0] tol, logic [15:0] lim,
                         logic [5:0] cc, logic [5:0] cr, logic [5:0] rad);
    settle();
    reg_write(RegInflowSpeed, spd);
    reg_write(RegTolerance, tol);
    reg_write(RegMaxSweeps, 32'(lim));
    reg_write(RegCylinderCol, 32'(cc));
    reg_write(RegCylinderRow, 32'(cr));
    reg_write(RegCylinderRadius, 32'(rad));
  endtask

  task automatic random_reads(int n, int solve_odds);
    for (int i = 0; i < n; i++) begin
      if (solve_odds > 0 && $urandom_range(solve_odds - 1) == 0)
        push_cmd(CmdSolve, 6'($urandom), 6'($urandom));
      else push_cmd(CmdRead, 6'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdRead;
    in_ch.col = '0;
    in_ch.row = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_all(32'h8000_0000, 32'd2147, 16'd2, 6'd32, 6'd32, 6'd8);
    push_cmd(CmdSolve, 6'd0, 6'd0);
    push_cmd(CmdRead, 6'd0, 6'd0);
    push_cmd(CmdRead, 6'd63, 6'd63);
    push_cmd(CmdRead, 6'd63, 6'd0);
    push_cmd(CmdRead, 6'd0, 6'd63);
    push_cmd(CmdRead, 6'd32, 6'd32);
    push_cmd(CmdRead, 6'd31, 6'd1);
    push_cmd(CmdRead, 6'd24, 6'd32);
    random_reads(150, 0);

    set_all(32'd0, 32'd0, 16'd3, 6'd0, 6'd0, 6'd63);
    push_cmd(CmdSolve, 6'd63, 6'd63);
    push_cmd(CmdRead, 6'd63, 6'd0);
    push_cmd(CmdRead, 6'd63, 6'd63);
    random_reads(100, 0);

    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 6'd63, 6'd0);
    push_cmd(CmdSolve, 6'd21, 6'd42);
    push_cmd(CmdRead, 6'd63, 6'd63);
    push_cmd(CmdRead, 6'd62, 6'd0);
    random_reads(100, 0);

    set_all(32'h8000_0000, 32'h8000_0000, 16'd0, 6'd10, 6'd50, 6'd5);
    push_cmd(CmdSolve, 6'd0, 6'd0);
    push_cmd(CmdRead, 6'd10, 6'd50);
    random_reads(100, 0);

    for (int p = 0; p < 4; p++) begin
      set_all($urandom_range(32'h8000_0000), $urandom_range(32'h0100_0000),
              16'($urandom_range(3, 1)), 6'($urandom), 6'($urandom),
              6'($urandom_range(12)));
      push_cmd(CmdSolve, 6'($urandom), 6'($urandom));
      random_reads(340, 170);
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
